// File: rtl/jtt_pkg.sv
package jtt_pkg;

    localparam int LOG_ENTRIES = 30;
    localparam int IDX_W       = $clog2(LOG_ENTRIES);
    localparam int CNT_W       = $clog2(LOG_ENTRIES + 1);
    localparam int BLK_W       = 32;
    localparam int OPS_W       = 5;
    localparam int HDR_W       = 5;
    localparam int AREA_W      = 11;
    localparam int MOP_W       = 5;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int TDATA_W     = 80;

    typedef enum logic [1:0] {
        ACT_BEGIN = 2'd0,
        ACT_END   = 2'd1,
        ACT_WRITE = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_WAIT     = 3'd1,
        ST_FULL     = 3'd2,
        ST_NO_OP    = 3'd3,
        ST_BAD_END  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_COPY   = 2'd1,
        CMD_HEADER = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_LOG_START = 2'd0,
        CFG_LOG_AREA  = 2'd1,
        CFG_MAX_OP    = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_APPEND,
        S_EMIT,
        S_CP_RD,
        S_CP_OUT,
        S_HDR
    } state_t;

    typedef struct packed {
        logic [BLK_W-1:0]  log_start;
        logic [AREA_W-1:0] log_area;
        logic [MOP_W-1:0]  max_op;
    } cfg_t;

    typedef struct packed {
        logic              load;
        status_t           status;
        cmd_t              command;
        logic [BLK_W-1:0]  src;
        logic [BLK_W-1:0]  dst;
        logic [HDR_W-1:0]  hdr;
        logic              last;
    } out_req_t;

endpackage

// File: rtl/jtt_ram.sv
module jtt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 30
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/jtt_core.sv
module jtt_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_action,
    input  logic [jtt_pkg::BLK_W-1:0]    in_block,
    input  jtt_pkg::cfg_t                cfg,
    input  logic                         out_free,
    output jtt_pkg::out_req_t            out_req
);

    jtt_pkg::state_t                state_reg, state_next;
    logic [jtt_pkg::CNT_W-1:0]      idx_reg, idx_next;
    logic [jtt_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [jtt_pkg::OPS_W-1:0]      open_reg, open_next;
    logic                           phase_reg, phase_next;
    logic [jtt_pkg::BLK_W-1:0]      blk_reg, blk_next;
    jtt_pkg::status_t               stat_reg, stat_next;

    logic                           ram_we;
    logic [jtt_pkg::BLK_W-1:0]      ram_rdata;
    logic [jtt_pkg::AREA_W-1:0]     need;
    logic                           log_full;
    logic                           scan_last;
    logic [jtt_pkg::BLK_W-1:0]      slot_blk;

    jtt_ram #(
        .WIDTH (jtt_pkg::BLK_W),
        .DEPTH (jtt_pkg::LOG_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[jtt_pkg::IDX_W-1:0]),
        .wdata (blk_reg),
        .raddr (idx_reg[jtt_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign need = jtt_pkg::AREA_W'(cnt_reg)
                + jtt_pkg::AREA_W'(jtt_pkg::AREA_W'(open_reg) + 1'b1)
                * jtt_pkg::AREA_W'(cfg.max_op);
    assign log_full = (cnt_reg >= jtt_pkg::CNT_W'(jtt_pkg::LOG_ENTRIES))
                   || (jtt_pkg::AREA_W'(cnt_reg) + 1'b1 >= cfg.log_area);
    assign scan_last = (idx_reg + 1'b1 == cnt_reg);
    assign slot_blk  = cfg.log_start + jtt_pkg::BLK_W'(idx_reg) + 1'b1;
    assign in_ready  = (state_reg == jtt_pkg::S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jtt_pkg::S_IDLE;
            cnt_reg   <= '0;
            open_reg  <= '0;
            idx_reg   <= '0;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            open_reg  <= open_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg  <= blk_next;
        stat_reg <= stat_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            jtt_pkg::S_IDLE: begin
                if (in_valid) begin
                    case (jtt_pkg::action_t'(in_action))
                        jtt_pkg::ACT_BEGIN: state_next = jtt_pkg::S_EMIT;
                        jtt_pkg::ACT_END: begin
                            if (open_reg == jtt_pkg::OPS_W'(1) && cnt_reg != '0)
                                state_next = jtt_pkg::S_CP_RD;
                            else
                                state_next = jtt_pkg::S_EMIT;
                        end
                        jtt_pkg::ACT_WRITE: begin
                            if (log_full || open_reg == '0)
                                state_next = jtt_pkg::S_EMIT;
                            else if (cnt_reg == '0)
                                state_next = jtt_pkg::S_APPEND;
                            else
                                state_next = jtt_pkg::S_SCAN_RD;
                        end
                        default: state_next = jtt_pkg::S_IDLE;
                    endcase
                end
            end
            jtt_pkg::S_SCAN_RD: state_next = jtt_pkg::S_SCAN_CMP;
            jtt_pkg::S_SCAN_CMP: begin
                if (ram_rdata == blk_reg)
                    state_next = jtt_pkg::S_EMIT;
                else if (scan_last)
                    state_next = jtt_pkg::S_APPEND;
                else
                    state_next = jtt_pkg::S_SCAN_RD;
            end
            jtt_pkg::S_APPEND: state_next = jtt_pkg::S_EMIT;
            jtt_pkg::S_EMIT: begin
                if (out_free)
                    state_next = jtt_pkg::S_IDLE;
            end
            jtt_pkg::S_CP_RD: state_next = jtt_pkg::S_CP_OUT;
            jtt_pkg::S_CP_OUT: begin
                if (out_free)
                    state_next = scan_last ? jtt_pkg::S_HDR : jtt_pkg::S_CP_RD;
            end
            jtt_pkg::S_HDR: begin
                if (out_free)
                    state_next = phase_reg ? jtt_pkg::S_IDLE : jtt_pkg::S_CP_RD;
            end
            default: state_next = jtt_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cnt_next   = cnt_reg;
        open_next  = open_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        blk_next   = blk_reg;
        stat_next  = stat_reg;
        ram_we     = 1'b0;
        out_req    = '0;
        case (state_reg)
            jtt_pkg::S_IDLE: begin
                if (in_valid) begin
                    blk_next   = in_block;
                    idx_next   = '0;
                    phase_next = 1'b0;
                    stat_next  = jtt_pkg::ST_OK;
                    case (jtt_pkg::action_t'(in_action))
                        jtt_pkg::ACT_BEGIN: begin
                            if (open_reg == '1
                                || need > jtt_pkg::AREA_W'(jtt_pkg::LOG_ENTRIES))
                                stat_next = jtt_pkg::ST_WAIT;
                            else
                                open_next = open_reg + 1'b1;
                        end
                        jtt_pkg::ACT_END: begin
                            if (open_reg == '0)
                                stat_next = jtt_pkg::ST_BAD_END;
                            else
                                open_next = open_reg - 1'b1;
                        end
                        jtt_pkg::ACT_WRITE: begin
                            if (log_full)
                                stat_next = jtt_pkg::ST_FULL;
                            else if (open_reg == '0)
                                stat_next = jtt_pkg::ST_NO_OP;
                        end
                        default: stat_next = jtt_pkg::ST_OK;
                    endcase
                end
            end
            jtt_pkg::S_SCAN_CMP: begin
                if (ram_rdata != blk_reg)
                    idx_next = idx_reg + 1'b1;
            end
            jtt_pkg::S_APPEND: begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            jtt_pkg::S_EMIT: begin
                out_req.load   = out_free;
                out_req.status = stat_reg;
                out_req.last   = 1'b1;
            end
            jtt_pkg::S_CP_OUT: begin
                out_req.load    = out_free;
                out_req.command = jtt_pkg::CMD_COPY;
                out_req.src     = phase_reg ? slot_blk : ram_rdata;
                out_req.dst     = phase_reg ? ram_rdata : slot_blk;
                if (out_free)
                    idx_next = idx_reg + 1'b1;
            end
            jtt_pkg::S_HDR: begin
                out_req.load    = out_free;
                out_req.command = jtt_pkg::CMD_HEADER;
                out_req.dst     = cfg.log_start;
                out_req.hdr     = phase_reg ? '0 : jtt_pkg::HDR_W'(cnt_reg);
                out_req.last    = phase_reg;
                if (out_free) begin
                    if (phase_reg) begin
                        cnt_next = '0;
                    end else begin
                        phase_next = 1'b1;
                        idx_next   = '0;
                    end
                end
            end
            default: begin
                out_req = '0;
            end
        endcase
    end

endmodule

// File: rtl/journal_transaction_tracker.sv
// Begin, non-committing end and rejected requests: one result each, issued from S_EMIT.
// Block write: table scan (S_SCAN_RD, S_SCAN_CMP), append if no match, then one result.
// Commit of n entries: 2*n+2 results, one table read per copy.
// s_tready is high only while no request is in work; one request at a time.
// aresetn (synchronous) clears counts and loads register defaults 0, 31, 10;
// the block table needs no clearing.
module journal_transaction_tracker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // block_number
    input  logic [1:0]                      s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [jtt_pkg::TDATA_W-1:0]     m_tdata,   // status, command, source_block,
                                                       // dest_block, header_count, pad
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [jtt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jtt_pkg::CFG_W-1:0]       cfg_data
);

    jtt_pkg::cfg_t                  cfg_reg, cfg_next;
    jtt_pkg::out_req_t              out_req;
    logic                           out_valid_reg, out_valid_next;
    jtt_pkg::out_req_t              out_data_reg;
    logic                           out_free;

    assign out_free = !out_valid_reg || m_tready;

    jtt_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_block  (s_tdata),
        .cfg       (cfg_reg),
        .out_free  (out_free),
        .out_req   (out_req)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (jtt_pkg::cfg_idx_t'(cfg_index))
                jtt_pkg::CFG_LOG_START: cfg_next.log_start = cfg_data;
                jtt_pkg::CFG_LOG_AREA:  cfg_next.log_area  = cfg_data[jtt_pkg::AREA_W-1:0];
                jtt_pkg::CFG_MAX_OP:    cfg_next.max_op    = cfg_data[jtt_pkg::MOP_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        if (out_req.load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.log_start <= '0;
            cfg_reg.log_area  <= jtt_pkg::AREA_W'(31);
            cfg_reg.max_op    <= jtt_pkg::MOP_W'(10);
            out_valid_reg     <= 1'b0;
        end else begin
            cfg_reg           <= cfg_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_req.load) begin
            out_data_reg <= out_req;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_data_reg.last;
    assign m_tdata  = {6'b0, out_data_reg.hdr, out_data_reg.dst, out_data_reg.src,
                       out_data_reg.command, out_data_reg.status};

endmodule
